// ----- design/eight_bit_alu_with_flags_top_defines.svh -----
// Assertion macros shared by the eight-bit ALU design files.
// Depends on nothing; each macro expects clk and rst_n in scope where it is used.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_TOP_DEFINES_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EBALU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EBALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ebalu_pkg.sv -----
// Shared types, operation codes and flag bit positions for the eight-bit ALU.
// Depends on nothing; used by every module of the block.
`default_nettype none

package ebalu_pkg;

  // Action codes.
  localparam logic [3:0] ACT_ADD = 4'd0;
  localparam logic [3:0] ACT_ADC = 4'd1;
  localparam logic [3:0] ACT_SUB = 4'd2;
  localparam logic [3:0] ACT_SBC = 4'd3;
  localparam logic [3:0] ACT_AND = 4'd4;
  localparam logic [3:0] ACT_XOR = 4'd5;
  localparam logic [3:0] ACT_CP  = 4'd6;
  localparam logic [3:0] ACT_INC = 4'd7;
  localparam logic [3:0] ACT_DEC = 4'd8;
  localparam logic [3:0] ACT_CB  = 4'd9;

  // CB group, taken from the upper two bits of the CB sub-opcode.
  localparam logic [1:0] CBG_SHIFT = 2'd0;
  localparam logic [1:0] CBG_BIT   = 2'd1;
  localparam logic [1:0] CBG_RES   = 2'd2;
  localparam logic [1:0] CBG_SET   = 2'd3;

  // Rotate and shift kinds, the lower three bits of the CB sub-opcode.
  localparam logic [2:0] SH_RLC = 3'd0;
  localparam logic [2:0] SH_RRC = 3'd1;
  localparam logic [2:0] SH_RL  = 3'd2;
  localparam logic [2:0] SH_RR  = 3'd3;
  localparam logic [2:0] SH_SLA = 3'd4;
  localparam logic [2:0] SH_SRA = 3'd5;
  localparam logic [2:0] SH_SLL = 3'd6;
  localparam logic [2:0] SH_SRL = 3'd7;

  // Flag bit positions.
  localparam int FL_C  = 0;
  localparam int FL_N  = 1;
  localparam int FL_PV = 2;
  localparam int FL_B3 = 3;
  localparam int FL_H  = 4;
  localparam int FL_B5 = 5;
  localparam int FL_Z  = 6;
  localparam int FL_S  = 7;

  typedef struct packed {
    logic [3:0] action;
    logic [4:0] cb_op;
    logic [7:0] acc_in;
    logic [7:0] operand;
    logic [7:0] flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags_out;
    logic       write_result;
  } alu_res_t;

  // One for an even number of set bits.
  function automatic logic even_par(input logic [7:0] v);
    return ~(^v);
  endfunction

endpackage

`default_nettype wire

// ----- design/ebalu_cb.sv -----
// CB group unit: rotates, shifts, bit test, bit reset and bit set.
// Depends on ebalu_pkg.
`default_nettype none

module ebalu_cb
  import ebalu_pkg::*;
(
  input  alu_req_t req,
  output alu_res_t res
);

  logic [7:0] v;
  logic [7:0] f;
  logic [2:0] bsel;
  logic [7:0] mask;
  logic [7:0] sh_val;
  logic       sh_c;

  assign v    = req.operand;
  assign f    = req.flags_in;
  assign bsel = req.cb_op[2:0];
  assign mask = 8'h01 << bsel;

  always_comb begin
    unique case (bsel)
      SH_RLC: begin
        sh_c = v[7]; sh_val = {v[6:0], v[7]};
      end
      SH_RRC: begin
        sh_c = v[0]; sh_val = {v[0], v[7:1]};
      end
      SH_RL: begin
        sh_c = v[7]; sh_val = {v[6:0], f[FL_C]};
      end
      SH_RR: begin
        sh_c = v[0]; sh_val = {f[FL_C], v[7:1]};
      end
      SH_SLA: begin
        sh_c = v[7]; sh_val = {v[6:0], 1'b0};
      end
      SH_SRA: begin
        sh_c = v[0]; sh_val = {v[7], v[7:1]};
      end
      SH_SLL: begin
        sh_c = v[7]; sh_val = {v[6:0], 1'b1};
      end
      SH_SRL: begin
        sh_c = v[0]; sh_val = {1'b0, v[7:1]};
      end
    endcase
  end

  always_comb begin
    res.result       = v;
    res.flags_out    = f;
    res.write_result = 1'b1;
    unique case (req.cb_op[4:3])
      CBG_SHIFT: begin
        res.result          = sh_val;
        res.flags_out[FL_C]  = sh_c;
        res.flags_out[FL_N]  = 1'b0;
        res.flags_out[FL_H]  = 1'b0;
        res.flags_out[FL_S]  = sh_val[7];
        res.flags_out[FL_Z]  = (sh_val == 8'h00);
        res.flags_out[FL_PV] = even_par(sh_val);
      end
      CBG_BIT: begin
        res.flags_out[FL_H] = 1'b1;
        res.flags_out[FL_N] = 1'b0;
        res.flags_out[FL_Z] = ~v[bsel];
        res.write_result    = 1'b0;
      end
      CBG_RES: begin
        res.result = v & ~mask;
      end
      CBG_SET: begin
        res.result = v | mask;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/ebalu_core.sv -----
// Combinational ALU datapath: shared 8-bit adder, logic ops, compare, inc/dec,
// and the CB unit. Depends on ebalu_pkg and ebalu_cb.
`default_nettype none

module ebalu_core
  import ebalu_pkg::*;
(
  input  alu_req_t req,
  output alu_res_t res
);

  logic [7:0] a;
  logic [7:0] v;
  logic [7:0] f;
  logic [7:0] add_x;
  logic [7:0] add_y;
  logic       add_cin;
  logic [8:0] sum;
  logic [7:0] sum8;
  logic       cout;
  logic       ovf;
  logic [7:0] add_fl;
  logic [7:0] lg;
  alu_res_t   cb_res;

  assign a = req.acc_in;
  assign v = req.operand;
  assign f = req.flags_in;

  ebalu_cb u_cb (
    .req (req),
    .res (cb_res)
  );

  // Operand steering for the single adder. Subtraction is a + ~b + 1, or a + ~b + ~C for SBC.
  always_comb begin
    add_x   = a;
    add_y   = v;
    add_cin = 1'b0;
    unique case (req.action)
      ACT_ADC: add_cin = f[FL_C];
      ACT_SUB, ACT_CP: begin
        add_y = ~v; add_cin = 1'b1;
      end
      ACT_SBC: begin
        add_y = ~v; add_cin = ~f[FL_C];
      end
      ACT_INC: begin
        add_x = v; add_y = 8'h01;
      end
      ACT_DEC: begin
        add_x = v; add_y = 8'hFE; add_cin = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum  = {1'b0, add_x} + {1'b0, add_y} + {8'h00, add_cin};
  assign sum8 = sum[7:0];
  assign cout = sum[8];
  assign ovf  = add_x[7] ^ add_y[7] ^ sum8[7] ^ cout;

  always_comb begin
    add_fl        = f;
    add_fl[FL_S]  = sum8[7];
    add_fl[FL_Z]  = (sum8 == 8'h00);
    add_fl[FL_PV] = ovf;
    add_fl[FL_C]  = cout;
  end

  assign lg = (req.action == ACT_AND) ? (a & v) : (a ^ v);

  always_comb begin
    res.result       = a;
    res.flags_out    = f;
    res.write_result = 1'b1;
    unique case (req.action)
      ACT_ADD, ACT_ADC: begin
        res.result          = sum8;
        res.flags_out       = add_fl;
        res.flags_out[FL_N] = 1'b0;
      end
      ACT_SUB, ACT_SBC: begin
        res.result          = sum8;
        res.flags_out       = add_fl;
        res.flags_out[FL_C] = ~cout;
        res.flags_out[FL_N] = 1'b1;
      end
      ACT_AND, ACT_XOR: begin
        res.result           = lg;
        res.flags_out[FL_C]  = 1'b0;
        res.flags_out[FL_N]  = 1'b0;
        res.flags_out[FL_H]  = 1'b0;
        res.flags_out[FL_S]  = lg[7];
        res.flags_out[FL_Z]  = (lg == 8'h00);
        res.flags_out[FL_PV] = even_par(lg);
      end
      ACT_CP: begin
        res.flags_out        = 8'h00;
        res.flags_out[FL_B3] = v[3];
        res.flags_out[FL_B5] = v[5];
        res.flags_out[FL_N]  = 1'b1;
        res.flags_out[FL_S]  = sum8[7];
        res.flags_out[FL_Z]  = (sum8 == 8'h00);
        res.flags_out[FL_C]  = ~cout;
        res.write_result     = 1'b0;
      end
      ACT_INC, ACT_DEC: begin
        res.result          = sum8;
        res.flags_out       = add_fl;
        res.flags_out[FL_C] = f[FL_C];
      end
      ACT_CB: begin
        res = cb_res;
      end
      default: begin
        res.write_result = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/eight_bit_alu_with_flags_top.sv -----
// Top level of the eight-bit ALU with Z80-style flags; uses ebalu_pkg, ebalu_core.
// An accepted beat is held in the input register and then in the result register,
// which raises out_valid.
// Throughput: one beat per cycle; busy is always low, since one pass of short
// combinational logic sits between the input register and the result register.
// Reset (rst_n low, synchronous) clears both valid bits; payload is not reset.
`default_nettype none
`include "eight_bit_alu_with_flags_top_defines.svh"

module eight_bit_alu_with_flags_top
  import ebalu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [3:0] in_action,
  input  wire logic [4:0] in_cb_op,
  input  wire logic [7:0] in_acc_in,
  input  wire logic [7:0] in_operand,
  input  wire logic [7:0] in_flags_in,
  output logic            out_valid,
  output logic [7:0]      out_result,
  output logic [7:0]      out_flags_out,
  output logic            out_write_result
);

  // The pipeline never stalls: the receiver must take every strobed beat, which the
  // block does not enforce; the block takes a new beat every cycle and busy stays low.
  logic     accept;
  alu_req_t req_r;
  alu_req_t req_nxt;
  logic     req_vld_r;
  alu_res_t core_res;
  alu_res_t res_r;
  logic     res_vld_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign req_nxt.action   = in_action;
  assign req_nxt.cb_op    = in_cb_op;
  assign req_nxt.acc_in   = in_acc_in;
  assign req_nxt.operand  = in_operand;
  assign req_nxt.flags_in = in_flags_in;

  // Input register stage. Only the valid bit is reset; the payload simply
  // follows the input on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_nxt;
    end
  end

  // All of the ALU work happens here, between the two register stages.
  ebalu_core u_core (
    .req (req_r),
    .res (core_res)
  );

  // Result register stage. Each result is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      res_r <= core_res;
    end
  end

  assign out_valid        = res_vld_r;
  assign out_result       = res_r.result;
  assign out_flags_out    = res_r.flags_out;
  assign out_write_result = res_r.write_result;

  // An accepted beat always reaches the input stage on the next edge.
  `EBALU_ASSERT_NEXT(a_req_load, accept, req_vld_r, "accepted beat did not enter input stage")

  // Every loaded input stage produces a result strobe in the following cycle.
  `EBALU_ASSERT_NEXT(a_res_follow, req_vld_r, out_valid, "input stage did not reach result")

  // A result that is not written back only ever returns the accumulator
  // (compare and unused actions) or the operand (bit test).
  `EBALU_ASSERT_IMPL(a_nowr_value, out_valid && !out_write_result, (out_result == $past(req_r.acc_in)) || (out_result == $past(req_r.operand)), "non-written result is not acc or operand")

endmodule

`default_nettype wire
